// ----- rtl/core/i2cmbs_pkg.sv -----
// shared command codes, phase counts and control structs of the i2c byte sequencer
`default_nettype none

package i2cmbs_pkg;

  // command codes on in_kind
  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_STOP  = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_ADDR  = 3'd4;

  // bus phases per command
  localparam int START_PHASES = 4;
  localparam int STOP_PHASES  = 3;
  localparam int BYTE_PHASES  = 19;
  localparam int PHASE_W      = $clog2(BYTE_PHASES);

  // bits clocked per byte command, data plus acknowledge slot
  localparam int BITS_PER_BYTE = 9;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture a new request
    logic emit;   // produce the next phase into the output register
  } i2cmbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a phase this cycle
    logic final_phase; // the current phase closes the run
  } i2cmbs_status_t;

  // valid command code check
  function automatic logic kind_known(input logic [2:0] kind);
    kind_known = kind inside {KIND_START, KIND_STOP, KIND_WRITE, KIND_READ, KIND_ADDR};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/i2cmbs_ctrl.sv -----
// controller state machine of the i2c byte sequencer
`default_nettype none

module i2cmbs_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic [2:0]             in_kind,
  output logic                        in_ready,
  input  wire i2cmbs_pkg::i2cmbs_status_t status,
  output i2cmbs_pkg::i2cmbs_cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && i2cmbs_pkg::kind_known(in_kind)) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.final_phase) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/i2cmbs_dp.sv -----
// datapath of the i2c byte sequencer: bit shifter, phase counter, output register
`default_nettype none

module i2cmbs_dp (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [2:0]             in_kind,
  input  wire logic [7:0]             in_tx_byte,
  input  wire logic [6:0]             in_target_address,
  input  wire logic                   in_read_not_write,
  input  wire logic                   in_send_ack,
  input  wire logic [8:0]             in_sda_samples,
  input  wire i2cmbs_pkg::i2cmbs_cmd_t cmd,
  output i2cmbs_pkg::i2cmbs_status_t  status,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_scl_level,
  output logic                        out_sda_level,
  output logic                        out_last_phase,
  output logic [7:0]                  out_rx_byte,
  output logic                        out_ack_seen
);

  localparam int PW = i2cmbs_pkg::PHASE_W;
  localparam int BW = i2cmbs_pkg::BITS_PER_BYTE;

  logic [2:0]    kind_r;
  logic [PW-1:0] phase_r;
  logic [BW-1:0] drive_r, drive_nxt;
  logic [BW-1:0] samples_r;
  logic          out_valid_r;
  logic          scl_r, sda_r, last_r, ack_r;
  logic [7:0]    rx_r;

  logic          is_byte;
  logic          ph_scl, ph_sda, ph_last, ph_ack;
  logic [7:0]    ph_rx;

  // bits to clock out for the new request, first bit at the top
  always_comb begin
    case (in_kind)
      i2cmbs_pkg::KIND_WRITE: drive_nxt = {in_tx_byte, 1'b1};
      i2cmbs_pkg::KIND_READ:  drive_nxt = {8'hFF, ~in_send_ack};
      i2cmbs_pkg::KIND_ADDR:  drive_nxt = {in_target_address, in_read_not_write, 1'b1};
      default:                drive_nxt = '1;
    endcase
  end

  assign is_byte = kind_r inside {i2cmbs_pkg::KIND_WRITE, i2cmbs_pkg::KIND_READ,
                                  i2cmbs_pkg::KIND_ADDR};

  // levels of the current phase
  always_comb begin
    ph_scl  = 1'b0;
    ph_sda  = 1'b1;
    ph_last = 1'b0;
    ph_rx   = '0;
    ph_ack  = 1'b0;
    case (kind_r)
      i2cmbs_pkg::KIND_START: begin
        ph_scl  = (phase_r < PW'(2));
        ph_sda  = (phase_r == PW'(0)) || (phase_r == PW'(3));
        ph_last = (phase_r == PW'(i2cmbs_pkg::START_PHASES - 1));
      end
      i2cmbs_pkg::KIND_STOP: begin
        ph_scl  = (phase_r != PW'(0));
        ph_sda  = (phase_r == PW'(2));
        ph_last = (phase_r == PW'(i2cmbs_pkg::STOP_PHASES - 1));
      end
      default: begin
        if (phase_r == PW'(i2cmbs_pkg::BYTE_PHASES - 1)) begin
          ph_last = 1'b1;
          ph_ack  = samples_r[0];
          if (kind_r == i2cmbs_pkg::KIND_READ) begin
            ph_rx = samples_r[8:1];
          end
        end else begin
          ph_scl = phase_r[0];
          ph_sda = drive_r[BW-1];
        end
      end
    endcase
  end

  assign status.out_free    = !out_valid_r || out_ready;
  assign status.final_phase = ph_last;

  // request capture, phase counter and bit shifter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      phase_r   <= '0;
      drive_r   <= drive_nxt;
      samples_r <= in_sda_samples;
    end else if (cmd.emit) begin
      phase_r <= phase_r + PW'(1);
      if (is_byte && phase_r[0]) begin
        drive_r <= {drive_r[BW-2:0], 1'b1};
      end
    end
  end

  // output register handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      scl_r  <= ph_scl;
      sda_r  <= ph_sda;
      last_r <= ph_last;
      rx_r   <= ph_rx;
      ack_r  <= ph_ack;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_level  = scl_r;
  assign out_sda_level  = sda_r;
  assign out_last_phase = last_r;
  assign out_rx_byte    = rx_r;
  assign out_ack_seen   = ack_r;

endmodule

`default_nettype wire

// ----- rtl/core/i2c_master_byte_sequencer_top.sv -----
// top level of the i2c master byte sequencer
// Input channel (in_*): one bus request per item: start, stop, write byte,
// read byte or write address, plus the SDA levels sampled at the nine SCL-high
// phases of a byte request. Output channel (out_*): one SCL/SDA phase per item,
// in bus order; out_last_phase marks the end of the run, where a byte request
// also carries the acknowledge bit, and a read request the received byte.
// A start yields 4 phases, a stop 3, a byte request 19; unknown codes are
// taken and yield nothing. Requests are handled one at a time: on acceptance
// the request is captured into the datapath, then its phases are registered
// into the output register in bus order, one phase per cycle while the
// receiver keeps out_ready high. The phase counter in the datapath advances
// with each phase that the controller emits into a free output register.
// in_ready is high whenever no run is in progress, also while the last phase
// still waits in the output register. When the receiver stalls, the current
// phase holds and the run pauses. Synchronous reset drops any run in progress
// and empties the output register; there is no state kept between requests.
`default_nettype none

module i2c_master_byte_sequencer_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_kind,
  input  wire logic [7:0] in_tx_byte,
  input  wire logic [6:0] in_target_address,
  input  wire logic       in_read_not_write,
  input  wire logic       in_send_ack,
  input  wire logic [8:0] in_sda_samples,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_scl_level,
  output logic            out_sda_level,
  output logic            out_last_phase,
  output logic [7:0]      out_rx_byte,
  output logic            out_ack_seen
);

  i2cmbs_pkg::i2cmbs_cmd_t    cmd;
  i2cmbs_pkg::i2cmbs_status_t status;

  // sequencing control
  i2cmbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // phase generation
  i2cmbs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_kind           (in_kind),
    .in_tx_byte        (in_tx_byte),
    .in_target_address (in_target_address),
    .in_read_not_write (in_read_not_write),
    .in_send_ack       (in_send_ack),
    .in_sda_samples    (in_sda_samples),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scl_level     (out_scl_level),
    .out_sda_level     (out_sda_level),
    .out_last_phase    (out_last_phase),
    .out_rx_byte       (out_rx_byte),
    .out_ack_seen      (out_ack_seen)
  );

endmodule

`default_nettype wire

// ----- rtl/core/i2cmbs_checker.sv -----
// port-level checker of the i2c byte sequencer and its bind
`default_nettype none

module i2cmbs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [2:0] in_kind,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_scl_level,
  input wire logic       out_sda_level,
  input wire logic       out_last_phase,
  input wire logic [7:0] out_rx_byte,
  input wire logic       out_ack_seen
);

  // a stalled phase holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scl_level) &&
    $stable(out_sda_level) && $stable(out_last_phase) && $stable(out_rx_byte))
    else $error("stalled phase changed");

  // a known request starts a run, so no further request is taken next cycle
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind <= i2cmbs_pkg::KIND_ADDR) |=> !in_ready)
    else $error("request taken during a run");

  // every run ends with sda released
  a_last_sda: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_phase |-> out_sda_level)
    else $error("final phase holds sda low");

  // received data only reported on the final phase
  a_rx_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_phase |-> (out_rx_byte == 8'd0) && !out_ack_seen)
    else $error("receive fields set before the final phase");

endmodule

bind i2c_master_byte_sequencer_top i2cmbs_checker u_i2cmbs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_kind        (in_kind),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_scl_level  (out_scl_level),
  .out_sda_level  (out_sda_level),
  .out_last_phase (out_last_phase),
  .out_rx_byte    (out_rx_byte),
  .out_ack_seen   (out_ack_seen)
);

`default_nettype wire

// ----- dv/i2c_master_byte_sequencer_top_tb.sv -----
// self-checking testbench for the i2c master byte sequencer: directed and random bus requests
`timescale 1ns / 100ps

module i2c_master_byte_sequencer_top_tb;

  // codes the block takes and drops without a phase
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  localparam int RANDOM_ITEMS  = 210;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 900000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic [6:0] target_address;
    logic       read_not_write;
    logic       send_ack;
    logic [8:0] sda_samples;
  } bus_req_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       last;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } bus_phase_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_kind = '0;
  logic [7:0] in_tx_byte = '0;
  logic [6:0] in_target_address = '0;
  logic       in_read_not_write = 1'b0;
  logic       in_send_ack = 1'b0;
  logic [8:0] in_sda_samples = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_scl_level;
  logic       out_sda_level;
  logic       out_last_phase;
  logic [7:0] out_rx_byte;
  logic       out_ack_seen;

  bus_phase_t pending_phases[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         random_sent = 0;
  bit         tx_idle_on = 1'b1;
  bit         rx_stall_on = 1'b1;

  i2c_master_byte_sequencer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_tx_byte        (in_tx_byte),
    .in_target_address (in_target_address),
    .in_read_not_write (in_read_not_write),
    .in_send_ack       (in_send_ack),
    .in_sda_samples    (in_sda_samples),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scl_level     (out_scl_level),
    .out_sda_level     (out_sda_level),
    .out_last_phase    (out_last_phase),
    .out_rx_byte       (out_rx_byte),
    .out_ack_seen      (out_ack_seen)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // idle length, mostly short with the odd long one
  function automatic int idle_len(input bit enabled);
    int pick;
    pick = $urandom_range(0, 99);
    if (!enabled || pick < 45) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_phase(input logic scl, input logic sda, input logic last,
                                     input logic [7:0] rx, input logic ack);
    bus_phase_t p;
    p.scl      = scl;
    p.sda      = sda;
    p.last     = last;
    p.rx_byte  = rx;
    p.ack_seen = ack;
    pending_phases.push_back(p);
  endfunction

  // phases the master drives for one request, in bus order
  function automatic void predict_phases(input bus_req_t r);
    logic [8:0] drive;
    logic       byte_cmd;
    logic       report_rx;
    byte_cmd  = 1'b1;
    report_rx = 1'b0;
    drive     = '1;
    case (r.kind)
      i2cmbs_pkg::KIND_START: begin
        push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
        push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        push_phase(1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
        byte_cmd = 1'b0;
      end
      i2cmbs_pkg::KIND_STOP: begin
        push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        push_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
        byte_cmd = 1'b0;
      end
      // data out, target drives the acknowledge slot
      i2cmbs_pkg::KIND_WRITE: drive = {r.tx_byte, 1'b1};
      // data released, master answers ack or nack
      i2cmbs_pkg::KIND_READ: begin
        drive     = {8'hFF, ~r.send_ack};
        report_rx = 1'b1;
      end
      i2cmbs_pkg::KIND_ADDR: drive = {r.target_address, r.read_not_write, 1'b1};
      default: byte_cmd = 1'b0;
    endcase
    if (byte_cmd) begin
      for (int i = i2cmbs_pkg::BITS_PER_BYTE - 1; i >= 0; i--) begin
        push_phase(1'b0, drive[i], 1'b0, 8'h00, 1'b0);
        push_phase(1'b1, drive[i], 1'b0, 8'h00, 1'b0);
      end
      push_phase(1'b0, 1'b1, 1'b1, report_rx ? r.sda_samples[8:1] : 8'h00, r.sda_samples[0]);
    end
  endfunction

  function automatic bus_req_t make_request(input logic [2:0] kind, input logic [7:0] tx,
                                            input logic [6:0] addr, input logic rnw,
                                            input logic ack, input logic [8:0] samples);
    bus_req_t r;
    r.kind           = kind;
    r.tx_byte        = tx;
    r.target_address = addr;
    r.read_not_write = rnw;
    r.send_ack       = ack;
    r.sda_samples    = samples;
    return r;
  endfunction

  function automatic bus_req_t random_request(input logic [2:0] kind);
    return make_request(kind, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        9'($urandom_range(0, 511)));
  endfunction

  // send one request; called and returns at a rising edge
  task automatic send_request(input bus_req_t r);
    int gap;
    gap = idle_len(tx_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= r.kind;
    in_tx_byte        <= r.tx_byte;
    in_target_address <= r.target_address;
    in_read_not_write <= r.read_not_write;
    in_send_ack       <= r.send_ack;
    in_sda_samples    <= r.sda_samples;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_phases(r);
  endtask

  // hold off the sender until every phase has come back
  task automatic drain_outstanding();
    in_valid <= 1'b0;
    while (pending_phases.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      stall = idle_len(rx_stall_on);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(input string field, input int expv, input int act);
    if (expv != act) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
                 field, cycle_count, expv, act);
    end
  endfunction

  // compare each phase with the oldest expectation
  always @(posedge clk) begin : phase_checker
    bus_phase_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_phases.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected phase at cycle %0d: scl %0b sda %0b last %0b",
                   cycle_count, out_scl_level, out_sda_level, out_last_phase);
      end else begin
        want = pending_phases.pop_front();
        check_field("scl_level", want.scl, out_scl_level);
        check_field("sda_level", want.sda, out_sda_level);
        check_field("last_phase", want.last, out_last_phase);
        check_field("rx_byte", want.rx_byte, out_rx_byte);
        check_field("ack_seen", want.ack_seen, out_ack_seen);
      end
    end
  end

  // every command with field extremes and the released-line cases
  task automatic test_directed_runs();
    send_request(make_request(i2cmbs_pkg::KIND_START, 8'hFF, 7'h7F, 1'b1, 1'b1, 9'h1FF));
    send_request(make_request(i2cmbs_pkg::KIND_ADDR, 8'h00, 7'h7F, 1'b1, 1'b0, 9'h000));
    send_request(make_request(i2cmbs_pkg::KIND_ADDR, 8'hFF, 7'h00, 1'b0, 1'b1, 9'h1FF));
    send_request(make_request(i2cmbs_pkg::KIND_ADDR, 8'h5A, 7'h55, 1'b0, 1'b0, 9'h001));
    send_request(make_request(i2cmbs_pkg::KIND_WRITE, 8'h00, 7'h7F, 1'b1, 1'b1, 9'h1FF));
    send_request(make_request(i2cmbs_pkg::KIND_WRITE, 8'hFF, 7'h00, 1'b0, 1'b0, 9'h000));
    send_request(make_request(i2cmbs_pkg::KIND_WRITE, 8'hA5, 7'h2A, 1'b1, 1'b0, 9'h0AA));
    send_request(make_request(i2cmbs_pkg::KIND_READ, 8'h00, 7'h00, 1'b0, 1'b1, 9'h1FF));
    send_request(make_request(i2cmbs_pkg::KIND_READ, 8'hFF, 7'h7F, 1'b1, 1'b0, 9'h000));
    send_request(make_request(i2cmbs_pkg::KIND_READ, 8'h3C, 7'h11, 1'b0, 1'b1, 9'h155));
    send_request(make_request(i2cmbs_pkg::KIND_READ, 8'hC3, 7'h6E, 1'b1, 1'b0, 9'h0AA));
    send_request(make_request(i2cmbs_pkg::KIND_STOP, 8'hFF, 7'h7F, 1'b1, 1'b1, 9'h1FF));
    send_request(make_request(i2cmbs_pkg::KIND_STOP, 8'h00, 7'h00, 1'b0, 1'b0, 9'h000));
    send_request(make_request(i2cmbs_pkg::KIND_START, 8'h00, 7'h00, 1'b0, 1'b0, 9'h000));
  endtask

  // unused codes are taken and yield nothing, then a real request must still run
  task automatic test_unknown_kinds();
    for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
      send_request(random_request(3'(k)));
    send_request(random_request(i2cmbs_pkg::KIND_STOP));
  endtask

  // random transactions: start, address, some bytes, maybe a repeated start, usually a stop
  task automatic test_bus_transactions();
    int       nbytes;
    bit       paused;
    bus_req_t r;
    paused = 1'b0;
    while (random_sent < RANDOM_ITEMS) begin
      // some stretches run with no idling on either side
      tx_idle_on  = ($urandom_range(0, 3) != 0);
      rx_stall_on = tx_idle_on;
      if (!paused && random_sent >= RANDOM_ITEMS / 2) begin
        drain_outstanding();
        paused = 1'b1;
      end
      if ($urandom_range(0, 4) != 0) begin
        send_request(random_request(i2cmbs_pkg::KIND_START));
        send_request(random_request(i2cmbs_pkg::KIND_ADDR));
        nbytes = $urandom_range(1, 4);
        repeat (nbytes) begin
          r = random_request($urandom_range(0, 1) ? i2cmbs_pkg::KIND_READ :
                                                     i2cmbs_pkg::KIND_WRITE);
          send_request(r);
        end
        if ($urandom_range(0, 3) == 0) begin
          send_request(random_request(i2cmbs_pkg::KIND_START));
          send_request(random_request(i2cmbs_pkg::KIND_ADDR));
          send_request(random_request(i2cmbs_pkg::KIND_READ));
          nbytes += 3;
        end
        if ($urandom_range(0, 5) != 0) begin
          send_request(random_request(i2cmbs_pkg::KIND_STOP));
          nbytes++;
        end
        random_sent += nbytes + 2;
      end else begin
        // noise and broken sequences, unused codes among them
        r = random_request(3'($urandom_range(0, 7)));
        send_request(r);
        if (r.kind < KIND_UNUSED_LO) random_sent++;
      end
    end
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  // sequencing
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_runs();
    test_unknown_kinds();
    test_bus_transactions();
    in_valid <= 1'b0;
    while (pending_phases.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_phases.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
